// ===== src/s2fe_pkg.sv =====
// Shared types, constants and packing helpers for the Steim2 frame encoder.
// Used by every module of the encoder; depends on nothing.
package s2fe_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int DIFF_W      = 30;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 10;
  localparam int FRAME_WORDS = 16;
  localparam int SLOT_W      = $clog2(FRAME_WORDS);
  localparam int WINDOW      = 7;
  localparam int CNT_W       = 3;
  localparam int LAYOUTS     = 7;
  localparam int SEL_W       = 3;
  localparam int MAX_FRAMES_DEF = 63;
  localparam int OUTQ_DEPTH  = 2;

  // Bit offset of the cnib for slot zero inside a control word
  localparam int CNIB_TOP = 30;

  // Fixed word places inside a record
  localparam logic [POS_W-1:0]  POS_X0 = POS_W'(1);
  localparam logic [POS_W-1:0]  POS_XN = POS_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_CTRL  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_DATA0 = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(FRAME_WORDS - 1);

  // Layout tables, tried in order: 7x4, 6x5, 5x6, 4x8, 3x10, 2x15, 1x30
  localparam int LAY_BITS  [LAYOUTS] = '{4, 5, 6, 8, 10, 15, 30};
  localparam int LAY_COUNT [LAYOUTS] = '{7, 6, 5, 4, 3, 2, 1};
  localparam int LAY_CNIB  [LAYOUTS] = '{3, 3, 3, 1, 2, 2, 2};
  localparam int LAY_DNIB  [LAYOUTS] = '{2, 1, 0, -1, 3, 2, 1};

  typedef logic [WINDOW-1:0][DIFF_W-1:0] win_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                fin;
    logic                first;
    logic                clip;
    logic [DIFF_W-1:0]   diff;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  position;
    logic              eor;
    logic              full;
    logic              clip;
  } result_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_PACK,
    ST_CTRL,
    ST_TAIL,
    ST_XN
  } state_t;

  // True when a 30-bit difference fits a signed field of the given width
  function automatic logic fits(logic [DIFF_W-1:0] d, int b);
    logic signed [DIFF_W-1:0] t;
    t = $signed(d) >>> (b - 1);
    return (t == '0) || (t == '1);
  endfunction

  // Build the data word of one layout, first difference most significant
  function automatic logic [WORD_W-1:0] pack_layout(win_t w, int k);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] mask;
    acc  = '0;
    mask = WORD_W'((64'd1 << LAY_BITS[k]) - 64'd1);
    for (int m = 0; m < WINDOW; m++) begin
      if (m < LAY_COUNT[k]) begin
        acc = acc | ((WORD_W'(w[m]) & mask) << (LAY_BITS[k] * (LAY_COUNT[k] - 1 - m)));
      end
    end
    if (LAY_DNIB[k] >= 0) begin
      acc[WORD_W-1:WORD_W-2] = 2'(LAY_DNIB[k]);
    end
    return acc;
  endfunction

endpackage

// ===== src/s2fe_diff.sv =====
// Input register of the encoder: forms the saturated first difference.
// Depends on s2fe_pkg for the item type and widths.
module s2fe_diff import s2fe_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       final_sample,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  output item_t                      item,
  output logic                       item_valid,
  input  logic                       item_take
);

  localparam logic signed [SAMPLE_W:0] SAT_HI = (SAMPLE_W+1)'((1 << (DIFF_W - 1)) - 1);
  localparam logic signed [SAMPLE_W:0] SAT_LO = -SAT_HI - 1;

  logic [SAMPLE_W-1:0]     prev;
  logic                    first_seen;
  logic                    clip_seen;
  logic                    accept;
  logic signed [SAMPLE_W:0] wide;
  logic [DIFF_W-1:0]       diff_sat;
  logic                    clip_hit;

  // Hold the request while the sequencer has not taken the last one
  assign sample_stall = item_valid && !item_take;
  assign accept       = sample_valid && !sample_stall;

  // Subtract and saturate to the 30-bit range
  always_comb begin
    wide     = $signed({sample[SAMPLE_W-1], sample}) - $signed({prev[SAMPLE_W-1], prev});
    clip_hit = 1'b0;
    diff_sat = wide[DIFF_W-1:0];
    if (!first_seen) begin
      diff_sat = '0;
    end else if (wide > SAT_HI) begin
      diff_sat = SAT_HI[DIFF_W-1:0];
      clip_hit = 1'b1;
    end else if (wide < SAT_LO) begin
      diff_sat = SAT_LO[DIFF_W-1:0];
      clip_hit = 1'b1;
    end
  end

  // Record state: cleared again after the final sample
  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen <= 1'b0;
      clip_seen  <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (accept) begin
        first_seen <= !final_sample;
        clip_seen  <= final_sample ? 1'b0 : (clip_seen | clip_hit);
        item_valid <= 1'b1;
      end else if (item_take) begin
        item_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      prev        <= sample;
      item.sample <= sample;
      item.fin    <= final_sample;
      item.first  <= !first_seen;
      item.clip   <= clip_seen | clip_hit;
      item.diff   <= diff_sat;
    end
  end

endmodule

// ===== src/s2fe_pack.sv =====
// Greedy Steim2 packer: picks the first layout that fits the pending window.
// Depends on s2fe_pkg for layout tables and helper functions.
module s2fe_pack import s2fe_pkg::*; (
  input  win_t              win,
  input  logic [CNT_W-1:0]  count,
  output logic [WORD_W-1:0] word,
  output logic [1:0]        cnib,
  output logic [CNT_W-1:0]  used,
  output win_t              rest
);

  logic [LAYOUTS-1:0] ok;
  logic [WORD_W-1:0]  cand [LAYOUTS];
  logic [SEL_W-1:0]   sel;

  // Check every layout in parallel
  always_comb begin
    for (int k = 0; k < LAYOUTS; k++) begin
      ok[k] = (LAY_COUNT[k] <= int'(count));
      for (int m = 0; m < WINDOW; m++) begin
        if (m < LAY_COUNT[k] && !fits(win[m], LAY_BITS[k])) begin
          ok[k] = 1'b0;
        end
      end
      cand[k] = pack_layout(win, k);
    end
  end

  // Take the first layout that fits; one difference at 30 bits always does
  always_comb begin
    sel = SEL_W'(LAYOUTS - 1);
    for (int k = LAYOUTS - 1; k >= 0; k--) begin
      if (ok[k]) begin
        sel = SEL_W'(k);
      end
    end
  end

  assign word = cand[sel];
  assign cnib = 2'(LAY_CNIB[sel]);
  assign used = CNT_W'(LAY_COUNT[sel]);

  // Shift out the differences just packed
  always_comb begin
    logic [CNT_W:0] idx;
    for (int i = 0; i < WINDOW; i++) begin
      idx     = (CNT_W+1)'(i) + {1'b0, used};
      rest[i] = (idx < (CNT_W+1)'(WINDOW)) ? win[idx[CNT_W-1:0]] : '0;
    end
  end

endmodule

// ===== src/s2fe_frame.sv =====
// Frame sequencer: keeps the difference window, frame and slot counters; it emits
// at most one record word per cycle while room is high. Depends on s2fe_pkg, s2fe_pack.
module s2fe_frame import s2fe_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_take,
  input  logic    room,
  output logic    push,
  output result_t res
);

  localparam int FRAME_W = $clog2(MAX_FRAMES + 1);
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(MAX_FRAMES);

  state_t               state, state_next;
  win_t                 pend, pend_next;
  logic [CNT_W-1:0]     pcount, pcount_next;
  logic [FRAME_W-1:0]   frame, frame_next;
  logic [SLOT_W-1:0]    slot, slot_next;
  logic [WORD_W-1:0]    ctrl, ctrl_next;
  logic                 full, full_next;
  logic [SAMPLE_W-1:0]  xn, xn_next;
  logic                 fin, fin_next;
  logic                 clip, clip_next;

  logic [WORD_W-1:0]    pk_word;
  logic [1:0]           pk_cnib;
  logic [CNT_W-1:0]     pk_used;
  win_t                 pk_rest;
  logic [CNT_W-1:0]     pcount_after;
  logic                 frame_full;
  logic                 tail_ctrl;
  logic                 appended;
  logic [CNT_W-1:0]     cnt_new;
  logic [4:0]           cn_shift;
  logic [FRAME_W+SLOT_W+POS_W-1:0] data_pos_w, ctrl_pos_w;
  logic [POS_W-1:0]     data_pos, ctrl_pos;

  s2fe_pack u_pack (
    .win   (pend),
    .count (pcount),
    .word  (pk_word),
    .cnib  (pk_cnib),
    .used  (pk_used),
    .rest  (pk_rest)
  );

  // Shared decode of the current counters
  assign pcount_after = pcount - pk_used;
  assign frame_full   = (frame == FRAME_LAST);
  assign tail_ctrl    = !frame_full && (slot > SLOT_DATA0);
  assign appended     = !frame_full;
  assign cnt_new      = appended ? (pcount + CNT_W'(1)) : pcount;
  assign cn_shift     = 5'(CNIB_TOP) - {slot, 1'b0};
  assign data_pos_w   = {{POS_W{1'b0}}, frame, slot};
  assign ctrl_pos_w   = {{POS_W{1'b0}}, frame, SLOT_CTRL};
  assign data_pos     = data_pos_w[POS_W-1:0];
  assign ctrl_pos     = ctrl_pos_w[POS_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    if (room) begin
      unique case (state)
        ST_RUN: begin
          if (item_valid) begin
            if (appended && pcount == CNT_W'(WINDOW - 1)) begin
              state_next = ST_PACK;
            end else if (item.fin) begin
              state_next = (cnt_new != '0) ? ST_PACK : ST_TAIL;
            end
          end
        end
        ST_PACK: begin
          if (frame_full) begin
            state_next = ST_TAIL;
          end else if (slot == SLOT_LAST) begin
            state_next = ST_CTRL;
          end else if (fin) begin
            state_next = (pcount_after != '0) ? ST_PACK : ST_TAIL;
          end else begin
            state_next = ST_RUN;
          end
        end
        ST_CTRL: begin
          if (fin) begin
            state_next = (pcount != '0) ? ST_PACK : ST_TAIL;
          end else begin
            state_next = ST_RUN;
          end
        end
        ST_TAIL: begin
          state_next = tail_ctrl ? ST_XN : ST_RUN;
        end
        ST_XN: begin
          state_next = ST_RUN;
        end
        default: state_next = ST_RUN;
      endcase
    end
  end

  // Outputs: at most one record word per cycle
  always_comb begin
    item_take    = 1'b0;
    push         = 1'b0;
    res.word     = xn;
    res.position = POS_XN;
    res.eor      = 1'b0;
    res.full     = full;
    res.clip     = clip;
    unique case (state)
      ST_RUN: begin
        item_take    = room && item_valid;
        push         = room && item_valid && item.first;
        res.word     = item.sample;
        res.position = POS_X0;
        res.clip     = item.clip;
      end
      ST_PACK: begin
        push         = room && !frame_full;
        res.word     = pk_word;
        res.position = data_pos;
      end
      ST_CTRL: begin
        push         = room;
        res.word     = ctrl;
        res.position = ctrl_pos;
      end
      ST_TAIL: begin
        push = room;
        if (tail_ctrl) begin
          res.word     = ctrl;
          res.position = ctrl_pos;
        end else begin
          res.eor = 1'b1;
        end
      end
      ST_XN: begin
        push    = room;
        res.eor = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Window, counters and control word
  always_comb begin
    pend_next   = pend;
    pcount_next = pcount;
    frame_next  = frame;
    slot_next   = slot;
    ctrl_next   = ctrl;
    full_next   = full;
    xn_next     = xn;
    fin_next    = fin;
    clip_next   = clip;
    if (room) begin
      case (state)
        ST_RUN: begin
          if (item_valid) begin
            xn_next   = item.sample;
            fin_next  = item.fin;
            clip_next = item.clip;
            if (frame_full) begin
              full_next = 1'b1;
            end else begin
              pend_next[pcount] = item.diff;
            end
            pcount_next = cnt_new;
          end
        end
        ST_PACK: begin
          if (frame_full) begin
            // Drop what is left of the window
            full_next   = 1'b1;
            pcount_next = '0;
          end else begin
            pend_next   = pk_rest;
            pcount_next = pcount_after;
            ctrl_next   = ctrl | (WORD_W'(pk_cnib) << cn_shift);
            slot_next   = slot + SLOT_W'(1);
          end
        end
        ST_CTRL: begin
          frame_next = frame + FRAME_W'(1);
          slot_next  = SLOT_DATA0;
          ctrl_next  = '0;
        end
        ST_TAIL, ST_XN: begin
          // Start the next record once Xn goes out
          if (state == ST_XN || !tail_ctrl) begin
            pcount_next = '0;
            frame_next  = '0;
            slot_next   = SLOT_FIRST;
            ctrl_next   = '0;
            full_next   = 1'b0;
            fin_next    = 1'b0;
          end
        end
        default: begin
          pcount_next = pcount;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      pcount <= '0;
      frame  <= '0;
      slot   <= SLOT_FIRST;
      ctrl   <= '0;
      full   <= 1'b0;
      fin    <= 1'b0;
    end else begin
      state  <= state_next;
      pcount <= pcount_next;
      frame  <= frame_next;
      slot   <= slot_next;
      ctrl   <= ctrl_next;
      full   <= full_next;
      fin    <= fin_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    xn   <= xn_next;
    clip <= clip_next;
  end

endmodule

// ===== src/s2fe_outq.sv =====
// Small output queue that parts the sequencer from the result channel.
// Depends on s2fe_pkg for the result type and queue depth.
module s2fe_outq import s2fe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t dout
);

  localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;

  result_t          entries [OUTQ_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;
  logic             pop;
  logic             do_push;

  assign room      = (count != (PTR_W+1)'(OUTQ_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign do_push   = push && room;
  assign dout      = entries[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= din;
    end
  end

endmodule

// ===== src/steim2_frame_encoder.sv =====
// Steim2 frame encoder: one signed sample per cycle in unless stalled, record words out.
// X0 of a record passes the difference register and the output queue before it is offered.
// Each data word, and a completed frame's control word, takes a sequencer state of its own
// in which no sample is taken, as the sequencer emits at most one word a cycle.
// A final sample is followed by its flushed data words, control word and Xn, and by a pass
// through ST_PACK when a full record drops its window. Reset (synchronous, active high)
// starts a new record; pending differences stay unset.
module steim2_frame_encoder import s2fe_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       final_sample,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  output logic [WORD_W-1:0]          word,
  output logic [POS_W-1:0]           position,
  output logic                       end_of_record,
  output logic                       record_full,
  output logic                       diff_clipped,
  output logic                       word_valid,
  input  logic                       word_stall
);

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    q_room;
  logic    q_push;
  result_t q_din;
  result_t q_dout;

  s2fe_diff u_diff (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .final_sample (final_sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .item         (item),
    .item_valid   (item_valid),
    .item_take    (item_take)
  );

  s2fe_frame #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .room       (q_room),
    .push       (q_push),
    .res        (q_din)
  );

  s2fe_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_din),
    .room      (q_room),
    .out_valid (word_valid),
    .out_stall (word_stall),
    .dout      (q_dout)
  );

  // Unpack the queue head onto the result ports
  assign word          = q_dout.word;
  assign position      = q_dout.position;
  assign end_of_record = q_dout.eor;
  assign record_full   = q_dout.full;
  assign diff_clipped  = q_dout.clip;

  // Xn always closes a record at its fixed place
  a_xn_place: assert property (@(posedge clk) disable iff (rst)
    word_valid && end_of_record |-> position == POS_XN)
    else $error("end of record word not at the Xn place");

  // Sequencer never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_room)
    else $error("push into full output queue");

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !word_valid)
    else $error("result offered right after reset");

endmodule
